// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lkv_pkg.sv =====
// Shared constants, codes and control types of the LRU key-value cache.
package lkv_pkg;

  // Storage geometry
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Occupancy counter holds up to ENTRIES + 1 (list length before trimming)
  localparam int CNT_W = $clog2(ENTRIES + 2);
  // Index into the ENTRIES + 1 slots of the shifted list
  localparam int SEL_W = $clog2(ENTRIES + 1);

  // Configuration port
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CAP_W;
  localparam int CMP_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_NEXT = 1'd1;
  localparam logic [CAP_W-1:0]     CAP_RESET    = 5'd16;

  // Request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_READ_HIT       = 2'd0,
    STAT_READ_FETCH     = 2'd1,
    STAT_READ_NOT_FOUND = 2'd2,
    STAT_WRITE_DONE     = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } fsm_state_t;

  // Controls from the sequencer to the chain
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic is_write;
  } chain_ctl_t;

  // Controls from the chain to one cell
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic shift_en;
    logic valid;
  } cell_ctl_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// A request passes the compare and update states; the result is registered at the end of the update state.
// The cells register their key matches in the compare state and shift the row in the update state;
// busy covers both, so a new request is taken only once the last one is through.
// Reset: empty cache, capacity 16, no next level, no result pending.
// The result is shown for one cycle only; the receiver cannot stall it.
`include "assert_macros.svh"

module lru_key_value_cache import lkv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_req_type,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_wr_value,
  // Result channel
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [VALUE_BITS-1:0] out_rd_value,
  output logic                  out_evict_valid,
  output logic [KEY_BITS-1:0]   out_evict_key,
  output logic [VALUE_BITS-1:0] out_evict_value,
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  fsm_state_t            state_r, state_nxt;
  logic                  accept;
  chain_ctl_t            cctl;

  logic [CAP_W-1:0]      cap_r;
  logic                  has_next_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      cap_eff;
  logic [CNT_W-1:0]      n_new;
  logic                  evict;
  logic [SEL_W-1:0]      ev_sel;

  logic                  req_type_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;

  logic [ENTRIES-1:0]    match_vec;
  logic                  hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic [KEY_BITS-1:0]   ev_key;
  logic [VALUE_BITS-1:0] ev_value;

  status_t               status_nxt;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VALUE_BITS-1:0] out_rd_value_r;
  logic                  out_evict_valid_r;
  logic [KEY_BITS-1:0]   out_evict_key_r;
  logic [VALUE_BITS-1:0] out_evict_value_r;

  assign accept = start && !busy;

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    busy          = 1'b1;
    cctl.cmp_en   = 1'b0;
    cctl.upd_en   = 1'b0;
    cctl.is_write = (req_type_r == REQ_WRITE);
    unique case (state_r)
      S_IDLE:  busy = 1'b0;
      S_CMP:   cctl.cmp_en = 1'b1;
      S_UPD:   cctl.upd_en = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r  <= in_req_type;
      req_key_r   <= in_key;
      req_value_r <= in_wr_value;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      has_next_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: cap_r      <= cfg_wdata[CAP_W-1:0];
        CFG_HAS_NEXT: has_next_r <= cfg_wdata[0];
      endcase
    end
  end

  // Effective capacity, clamped to 1..ENTRIES
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // List length after a write, trimming and eviction slot
  assign n_new     = count_r + CNT_W'(1) - CNT_W'(hit);
  assign evict     = n_new > cap_eff;
  assign ev_sel    = SEL_W'(n_new - CNT_W'(1));
  assign count_nxt = evict ? cap_eff : n_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cctl.upd_en && cctl.is_write) begin
      count_r <= count_nxt;
    end
  end

  lkv_chain u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (cctl),
    .req_key     (req_key_r),
    .req_value   (req_value_r),
    .count       (count_r),
    .ev_sel      (ev_sel),
    .match_vec   (match_vec),
    .hit         (hit),
    .hit_value   (hit_value),
    .evict_key   (ev_key),
    .evict_value (ev_value)
  );

  // Result status
  always_comb begin
    priority if (cctl.is_write) begin
      status_nxt = STAT_WRITE_DONE;
    end else if (hit) begin
      status_nxt = STAT_READ_HIT;
    end else if (has_next_r) begin
      status_nxt = STAT_READ_FETCH;
    end else begin
      status_nxt = STAT_READ_NOT_FOUND;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cctl.upd_en;
    end
  end

  // Result payload, taken in the update cycle
  always_ff @(posedge clk) begin
    if (cctl.upd_en) begin
      out_status_r      <= status_nxt;
      out_rd_value_r    <= (!cctl.is_write && hit) ? hit_value : '0;
      out_evict_valid_r <= cctl.is_write && evict;
      out_evict_key_r   <= (cctl.is_write && evict) ? ev_key : '0;
      out_evict_value_r <= (cctl.is_write && evict) ? ev_value : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_rd_value    = out_rd_value_r;
  assign out_evict_valid = out_evict_valid_r;
  assign out_evict_key   = out_evict_key_r;
  assign out_evict_value = out_evict_value_r;

  // Checks
  `ASSERT_IMPLY(a_strobe_after_upd, out_valid, $past(state_r == S_UPD), "strobe without update")
  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(ENTRIES), "occupancy beyond row length")
  `ASSERT_ALWAYS(a_match_onehot0, $onehot0(match_vec), "key held in more than one cell")
  `ASSERT_NEXT(a_write_fills, cctl.upd_en && cctl.is_write, count_r != '0, "write left cache empty")

endmodule

// ===== rtl/lkv_cell.sv =====
// One cache cell: holds a key/value pair, compares its key, takes its neighbor's pair on shift.
module lkv_cell import lkv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctl_t             ctl,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [VALUE_BITS-1:0] prev_value,
  output logic [KEY_BITS-1:0]   key_r,
  output logic [VALUE_BITS-1:0] value_r,
  output logic [KEY_BITS-1:0]   key_nxt,
  output logic [VALUE_BITS-1:0] value_nxt,
  output logic                  match_r
);

  // Shift in from the neighbor closer to the front
  assign key_nxt   = (ctl.upd_en && ctl.shift_en) ? prev_key : key_r;
  assign value_nxt = (ctl.upd_en && ctl.shift_en) ? prev_value : value_r;

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  // Match flag, only for occupied cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      match_r <= ctl.valid && (cmp_key == key_r);
    end
  end

endmodule

// ===== rtl/lkv_chain.sv =====
// Row of cells in recency order, with the hit and eviction selection around it.
module lkv_chain import lkv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chain_ctl_t            ctl,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [VALUE_BITS-1:0] req_value,
  input  logic [CNT_W-1:0]      count,
  input  logic [SEL_W-1:0]      ev_sel,
  output logic [ENTRIES-1:0]    match_vec,
  output logic                  hit,
  output logic [VALUE_BITS-1:0] hit_value,
  output logic [KEY_BITS-1:0]   evict_key,
  output logic [VALUE_BITS-1:0] evict_value
);

  logic [KEY_BITS-1:0]   key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] val_q   [ENTRIES];
  logic [KEY_BITS-1:0]   key_n   [ENTRIES];
  logic [VALUE_BITS-1:0] val_n   [ENTRIES];
  logic [KEY_BITS-1:0]   prev_k  [ENTRIES];
  logic [VALUE_BITS-1:0] prev_v  [ENTRIES];
  logic [KEY_BITS-1:0]   hit_key;
  logic [KEY_BITS-1:0]   front_key;
  logic [VALUE_BITS-1:0] front_value;

  assign hit = |match_vec;

  // Pick the hit entry (at most one cell matches)
  always_comb begin
    hit_key   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_key   = hit_key   | (key_q[i] & {KEY_BITS{match_vec[i]}});
      hit_value = hit_value | (val_q[i] & {VALUE_BITS{match_vec[i]}});
    end
  end

  // New front entry: the written pair, or the hit pair on a read
  assign front_key   = ctl.is_write ? req_key : hit_key;
  assign front_value = ctl.is_write ? req_value : hit_value;

  // Cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_ctl_t cctl;

    if (i == 0) begin : g_front
      assign prev_k[i] = front_key;
      assign prev_v[i] = front_value;
    end else begin : g_rest
      assign prev_k[i] = key_q[i-1];
      assign prev_v[i] = val_q[i-1];
    end

    // Cells up to the hit position shift; a write miss shifts the whole row
    assign cctl.cmp_en   = ctl.cmp_en;
    assign cctl.upd_en   = ctl.upd_en;
    assign cctl.shift_en = (ctl.is_write && !hit) || (|(match_vec >> i));
    assign cctl.valid    = CNT_W'(i) < count;

    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cctl),
      .cmp_key    (req_key),
      .prev_key   (prev_k[i]),
      .prev_value (prev_v[i]),
      .key_r      (key_q[i]),
      .value_r    (val_q[i]),
      .key_nxt    (key_n[i]),
      .value_nxt  (val_n[i]),
      .match_r    (match_vec[i])
    );
  end

  // Last entry of the shifted list; the slot past the row is the entry shifted out
  always_comb begin
    evict_key   = (ev_sel == SEL_W'(ENTRIES)) ? key_q[ENTRIES-1] : '0;
    evict_value = (ev_sel == SEL_W'(ENTRIES)) ? val_q[ENTRIES-1] : '0;
    for (int j = 0; j < ENTRIES; j++) begin
      evict_key   = evict_key   | (key_n[j] & {KEY_BITS{ev_sel == SEL_W'(j)}});
      evict_value = evict_value | (val_n[j] & {VALUE_BITS{ev_sel == SEL_W'(j)}});
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the LRU key-value cache: directed and random request traffic.
module testbench import lkv_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESULT_LATENCY = 3;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int POOL_SIZE      = 24;
  localparam int MAX_REPORTS    = 10;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] val_t;

  // One predicted result transaction
  typedef struct packed {
    status_t status;
    val_t    rd_value;
    logic    evict_valid;
    key_t    evict_key;
    val_t    evict_value;
  } cache_result_t;

  logic clk;
  logic rst_n = 1'b0;

  // DUT inputs start at known values
  logic                  start       = 1'b0;
  logic                  in_req_type = REQ_READ;
  key_t                  in_key      = '0;
  val_t                  in_wr_value = '0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  logic       busy;
  logic       out_valid;
  logic [1:0] out_status;
  val_t       out_rd_value;
  logic       out_evict_valid;
  key_t       out_evict_key;
  val_t       out_evict_value;

  lru_key_value_cache i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_wr_value     (in_wr_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_rd_value    (out_rd_value),
    .out_evict_valid (out_evict_valid),
    .out_evict_key   (out_evict_key),
    .out_evict_value (out_evict_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Mirror of the cache contents, most recent entry first
  key_t                 held_keys [ENTRIES];
  val_t                 held_vals [ENTRIES];
  int                   held_count   = 0;
  logic [CAP_W-1:0]     cap_setting  = CAP_RESET;
  logic                 next_setting = 1'b0;

  cache_result_t expected_results [$];
  key_t          key_pool [POOL_SIZE];

  int requests_sent   = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  int config_writes   = 0;
  int read_hits       = 0;
  int read_fetches    = 0;
  int read_not_found  = 0;
  int writes_done     = 0;
  int evictions       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cache lookup and LRU update for one request; returns the result it causes
  function automatic cache_result_t predict_access(input logic rt, input key_t k,
                                                   input val_t v);
    cache_result_t res;
    key_t          list_keys [ENTRIES+1];
    val_t          list_vals [ENTRIES+1];
    int            pos;
    int            n;
    int            lim;
    res = '0;
    pos = -1;
    for (int i = 0; i < held_count; i++) begin
      if (pos < 0 && held_keys[i] == k) pos = i;
    end
    if (rt == REQ_READ) begin
      if (pos >= 0) begin
        res.status   = STAT_READ_HIT;
        res.rd_value = held_vals[pos];
        // Move the hit entry to the front
        for (int p = pos; p > 0; p--) begin
          held_keys[p] = held_keys[p-1];
          held_vals[p] = held_vals[p-1];
        end
        held_keys[0] = k;
        held_vals[0] = res.rd_value;
        read_hits++;
      end else if (next_setting) begin
        res.status = STAT_READ_FETCH;
        read_fetches++;
      end else begin
        res.status = STAT_READ_NOT_FOUND;
        read_not_found++;
      end
    end else begin
      // New list: written key first, then the others in recency order
      list_keys[0] = k;
      list_vals[0] = v;
      n = 1;
      for (int i = 0; i < held_count; i++) begin
        if (i != pos) begin
          list_keys[n] = held_keys[i];
          list_vals[n] = held_vals[i];
          n++;
        end
      end
      lim = cap_setting;
      if (lim < 1) lim = 1;
      if (lim > ENTRIES) lim = ENTRIES;
      // Trim to capacity; only the least recent dropped entry is reported
      if (n > lim) begin
        res.evict_valid = 1'b1;
        res.evict_key   = list_keys[n-1];
        res.evict_value = list_vals[n-1];
        n = lim;
        evictions++;
      end
      for (int i = 0; i < n; i++) begin
        held_keys[i] = list_keys[i];
        held_vals[i] = list_vals[i];
      end
      held_count = n;
      res.status = STAT_WRITE_DONE;
      writes_done++;
    end
    return res;
  endfunction

  // Key choice for random traffic: held keys, a small pool, or anything
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 35 && held_count > 0) return held_keys[$urandom_range(held_count - 1)];
    if (r < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return key_t'($urandom);
  endfunction

  // Present one request and hold it until the cache takes it; start stays high
  task automatic send_request(input logic rt, input key_t k, input val_t v);
    start       <= 1'b1;
    in_req_type <= rt;
    in_key      <= k;
    in_wr_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(predict_access(rt, k, v));
    requests_sent++;
  endtask

  // Drop start, wait for every pending result and let the pipeline empty
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == CFG_CAPACITY) cap_setting = data;
    else next_setting = data[0];
    config_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [CAP_W-1:0] cap, input logic has_next);
    settle();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_HAS_NEXT, CFG_DATA_W'(has_next));
  endtask

  // Hits, misses and updates at the key and value extremes
  task automatic test_hits_and_misses();
    apply_config(5'd16, 1'b0);
    send_request(REQ_READ,  '0, '1);
    send_request(REQ_WRITE, '0, '1);
    send_request(REQ_WRITE, '1, '0);
    send_request(REQ_READ,  '0, '0);
    send_request(REQ_READ,  key_t'(1), '1);
    send_request(REQ_WRITE, '0, val_t'(32'h1234_5678));
    send_request(REQ_READ,  '1, '1);
  endtask

  // Miss reports a fetch, the fetched value comes back as a write
  task automatic test_next_level_fetch();
    apply_config(5'd16, 1'b1);
    send_request(REQ_READ,  key_t'(32'hA5A5_5A5A), '0);
    send_request(REQ_WRITE, key_t'(32'hA5A5_5A5A), val_t'(32'h5A5A_A5A5));
    send_request(REQ_READ,  key_t'(32'hA5A5_5A5A), '0);
  endtask

  // Capacity zero behaves as one entry
  task automatic test_capacity_zero();
    apply_config(5'd0, 1'b0);
    send_request(REQ_WRITE, key_t'(32'h0000_0010), val_t'(32'h0000_0100));
    send_request(REQ_WRITE, key_t'(32'h0000_0020), val_t'(32'h0000_0200));
    send_request(REQ_READ,  key_t'(32'h0000_0010), '0);
    send_request(REQ_READ,  key_t'(32'h0000_0020), '0);
  endtask

  // Capacity lowered below occupancy: reads keep everything, next write trims
  task automatic test_capacity_shrink();
    apply_config(5'd4, 1'b0);
    for (int i = 1; i <= 4; i++) send_request(REQ_WRITE, key_t'(i * 3), val_t'(i * 7));
    send_request(REQ_READ, key_t'(6), '0);
    apply_config(5'd1, 1'b0);
    send_request(REQ_READ,  key_t'(9), '0);
    send_request(REQ_WRITE, key_t'(32'hFFFF_0000), val_t'(32'h0000_FFFF));
  endtask

  // Random reads and writes over a small key pool, configuration changed per chunk
  task automatic test_random_traffic(input int items, input int idle_pct);
    logic [CAP_W-1:0] cap;
    int               chunk_len;
    chunk_len = items / 6;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom);
    for (int chunk = 0; chunk < 6; chunk++) begin
      case (chunk)
        0: cap = 5'd31;
        1: cap = 5'd1;
        3: cap = 5'd0;
        4: cap = 5'd16;
        default: cap = CAP_W'($urandom_range(31));
      endcase
      apply_config(cap, 1'($urandom_range(1)));
      for (int n = 0; n < chunk_len; n++) begin
        while ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
        send_request(1'($urandom_range(1)), pick_key(), val_t'($urandom));
      end
    end
  endtask

  // Result checker: each strobe is compared with the oldest expectation
  always @(posedge clk) begin : result_check
    cache_result_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: status=%0d rd=%h evict=%b key=%h val=%h",
                   $realtime, out_status, out_rd_value, out_evict_valid,
                   out_evict_key, out_evict_value);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_status !== want.status || out_rd_value !== want.rd_value ||
            out_evict_valid !== want.evict_valid || out_evict_key !== want.evict_key ||
            out_evict_value !== want.evict_value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on result %0d", $realtime, results_checked);
            $display("  expected: status=%0d rd=%h evict=%b key=%h val=%h",
                     want.status, want.rd_value, want.evict_valid,
                     want.evict_key, want.evict_value);
            $display("  actual:   status=%0d rd=%h evict=%b key=%h val=%h",
                     out_status, out_rd_value, out_evict_valid,
                     out_evict_key, out_evict_value);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_hits_and_misses();
    test_next_level_fetch();
    test_capacity_zero();
    test_capacity_shrink();
    test_random_traffic(600, 6);
    test_random_traffic(600, 74);
    test_random_traffic(600, 0);

    settle();
    repeat (2 * RESULT_LATENCY) @(posedge clk);

    $display("Covered %0d requests in %0d cycles: %0d read hits, %0d fetch misses, %0d not-found",
             requests_sent, cycle_count, read_hits, read_fetches, read_not_found);
    $display("  %0d writes with %0d evictions, %0d register writes, %0d results checked",
             writes_done, evictions, config_writes, results_checked);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lkv_chain.sv
rtl/lru_key_value_cache.sv
dv/testbench.sv
